// ===== sv/lr_pkg.sv =====
package lr_pkg;

  localparam int COLOR_BITS = 24;

  // op field codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // per-line direction flags
  typedef struct packed {
    logic major_is_y;
    logic step_x_negative;
    logic step_y_negative;
  } lr_dir_t;

endpackage

// ===== sv/lr_setup.sv =====
module lr_setup
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  output lr_dir_t                 dir,
  output logic [COORD_BITS-1:0]   delta_major,
  output logic [COORD_BITS-1:0]   delta_minor,
  output logic signed [COORD_BITS+1:0] error_init,
  output logic                    active
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  always_comb begin
    dir.step_x_negative = end_x < start_x;
    dir.step_y_negative = end_y < start_y;
    dx = dir.step_x_negative ? (start_x - end_x) : (end_x - start_x);
    dy = dir.step_y_negative ? (start_y - end_y) : (end_y - start_y);
    // ties go to x
    dir.major_is_y = dy > dx;
    delta_major = dir.major_is_y ? dy : dx;
    delta_minor = dir.major_is_y ? dx : dy;
    // 2*minor - major, doubled decision form
    error_init = signed'({1'b0, delta_minor, 1'b0}) - signed'({2'b00, delta_major});
    active = delta_major != '0;
  end

endmodule

// ===== sv/lr_step.sv =====
module lr_step
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        pos_x,
  input  logic [COORD_BITS-1:0]        pos_y,
  input  logic [COORD_BITS-1:0]        target_x,
  input  logic [COORD_BITS-1:0]        target_y,
  input  logic [COORD_BITS-1:0]        delta_major,
  input  logic [COORD_BITS-1:0]        delta_minor,
  input  lr_dir_t                      dir,
  input  logic signed [COORD_BITS+1:0] error_term,
  output logic [COORD_BITS-1:0]        pos_x_next,
  output logic [COORD_BITS-1:0]        pos_y_next,
  output logic signed [COORD_BITS+1:0] error_next,
  output logic                         done
);

  localparam int EW = COORD_BITS + 2;

  logic                  minor_step;
  logic                  step_x;
  logic                  step_y;
  logic signed [EW:0]    err_sum;

  always_comb begin
    minor_step = error_term > 0;
    step_x = dir.major_is_y ? minor_step : 1'b1;
    step_y = dir.major_is_y ? 1'b1 : minor_step;

    pos_x_next = pos_x;
    if (step_x) begin
      pos_x_next = dir.step_x_negative ? pos_x - 1'b1 : pos_x + 1'b1;
    end
    pos_y_next = pos_y;
    if (step_y) begin
      pos_y_next = dir.step_y_negative ? pos_y - 1'b1 : pos_y + 1'b1;
    end

    // sum kept one bit wider; result always fits back into EW bits
    err_sum = {error_term[EW-1], error_term} + signed'({2'b00, delta_minor, 1'b0});
    if (minor_step) begin
      err_sum = err_sum - signed'({2'b00, delta_major, 1'b0});
    end
    error_next = err_sum[EW-1:0];

    done = dir.major_is_y ? (pos_y_next == target_y) : (pos_x_next == target_x);
  end

endmodule

// ===== sv/line_rasterizer_core.sv =====
// A pixel appears on the output register in the cycle after its advance transaction.
// Throughput: one transaction per cycle; a start transaction or an idle advance is taken
// even while a pixel waits on the output, a pixel-producing advance needs the register free.
// Reset: synchronous active-high rst drops any active line and empties the output register.
module line_rasterizer_core
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,

  // command channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COLOR_BITS-1:0] color,

  // pixel channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0] pixel_color,
  output logic                  last_pixel
);

  // Line state: current pixel, end point, axis lengths, direction and error.
  logic [COORD_BITS-1:0]        pos_x;
  logic [COORD_BITS-1:0]        pos_y;
  logic [COORD_BITS-1:0]        target_x;
  logic [COORD_BITS-1:0]        target_y;
  logic [COORD_BITS-1:0]        delta_major;
  logic [COORD_BITS-1:0]        delta_minor;
  lr_dir_t                      dir;
  logic signed [COORD_BITS+1:0] error_term;
  logic [COLOR_BITS-1:0]        line_color;
  logic                         line_active;

  // setup results for a start transaction
  lr_dir_t                      setup_dir;
  logic [COORD_BITS-1:0]        setup_major;
  logic [COORD_BITS-1:0]        setup_minor;
  logic signed [COORD_BITS+1:0] setup_error;
  logic                         setup_active;

  // one Bresenham step from the current state
  logic [COORD_BITS-1:0]        pos_x_next;
  logic [COORD_BITS-1:0]        pos_y_next;
  logic signed [COORD_BITS+1:0] error_next;
  logic                         step_done;

  logic                         is_start;
  logic                         emits;
  logic                         in_fire;

  lr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .dir         (setup_dir),
    .delta_major (setup_major),
    .delta_minor (setup_minor),
    .error_init  (setup_error),
    .active      (setup_active)
  );

  lr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .target_x    (target_x),
    .target_y    (target_y),
    .delta_major (delta_major),
    .delta_minor (delta_minor),
    .dir         (dir),
    .error_term  (error_term),
    .pos_x_next  (pos_x_next),
    .pos_y_next  (pos_y_next),
    .error_next  (error_next),
    .done        (step_done)
  );

  // Only an advance on an active line produces a pixel; everything else
  // passes regardless of the output register.
  assign is_start = (op == OP_START);
  assign emits    = (op == OP_ADVANCE) && line_active;
  assign in_ready = !emits || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (in_fire) begin
      if (is_start) begin
        line_active <= setup_active;
      end else if (emits && step_done) begin
        line_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (is_start) begin
        // a start drops whatever line was running
        pos_x       <= start_x;
        pos_y       <= start_y;
        target_x    <= end_x;
        target_y    <= end_y;
        line_color  <= color;
        dir         <= setup_dir;
        delta_major <= setup_major;
        delta_minor <= setup_minor;
        error_term  <= setup_error;
      end else if (emits) begin
        pos_x      <= pos_x_next;
        pos_y      <= pos_y_next;
        error_term <= error_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emits) begin
      pixel_x     <= pos_x;
      pixel_y     <= pos_y;
      pixel_color <= line_color;
      last_pixel  <= step_done;
    end
  end

endmodule
